@@ rtl/smm_pkg.sv @@
// ----------------------------------------------------------------------------
// Square matrix multiplier package
// Shared widths, opcodes and the control word that drives the MAC datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_DIMENSION = 16;
  localparam int DEFAULT_ELEMENT_WIDTH = 16;

  // Fixed field widths of the stream and configuration ports.
  localparam int OPCODE_WIDTH  = 2;
  localparam int VALUE_WIDTH   = 16;
  localparam int PRODUCT_WIDTH = 36;
  localparam int INDEX_WIDTH   = 4;
  localparam int SIZE_WIDTH    = 5;
  localparam int OUT_DATA_WIDTH = 48;

  // Matrix size after reset.
  localparam int SIZE_RESET = 16;

  // Opcodes carried in tuser.
  localparam logic [OPCODE_WIDTH-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_COMPUTE    = 2'd2;

  // Control word from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic clear;  // start of a new dot product
    logic issue;  // a read pair was issued to both stores this cycle
    logic last;   // the issued pair is the final term of the dot product
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/smm_ram.sv @@
// ----------------------------------------------------------------------------
// Matrix store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/smm_mac.sv @@
// ----------------------------------------------------------------------------
// Multiply-accumulate datapath
// Registered multiply of the two store outputs followed by a 36-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_mac #(
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire smm_pkg::mac_ctrl_t                 ctrl,
  input  wire logic [ELEMENT_WIDTH-1:0]           left_data,
  input  wire logic [ELEMENT_WIDTH-1:0]           right_data,
  output logic      [smm_pkg::PRODUCT_WIDTH-1:0]  acc,
  output logic                                    done
);

  import smm_pkg::*;

  localparam int ProdWidth = 2 * ELEMENT_WIDTH;

  logic                           rd_vld_r,   rd_vld_nxt;
  logic                           rd_last_r,  rd_last_nxt;
  logic                           prod_vld_r, prod_vld_nxt;
  logic                           prod_last_r, prod_last_nxt;
  logic                           done_r,     done_nxt;
  logic signed [ProdWidth-1:0]    prod_r,     prod_nxt;
  logic [PRODUCT_WIDTH-1:0]       acc_r,      acc_nxt;
  logic signed [ProdWidth+PRODUCT_WIDTH-1:0] prod_wide;

  always_comb begin
    // Read data follows the issue through the store read register, the product through the product register.
    rd_vld_nxt    = ctrl.issue;
    rd_last_nxt   = ctrl.issue & ctrl.last;
    prod_vld_nxt  = rd_vld_r;
    prod_last_nxt = rd_last_r;
    prod_nxt      = $signed(left_data) * $signed(right_data);
    prod_wide     = prod_r;
    acc_nxt       = acc_r;
    done_nxt      = done_r;
    if (ctrl.clear) begin
      acc_nxt  = '0;
      done_nxt = 1'b0;
    end else if (prod_vld_r) begin
      // Sum is kept modulo 2^36, which is exact at the default widths.
      acc_nxt  = acc_r + prod_wide[PRODUCT_WIDTH-1:0];
      done_nxt = prod_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      prod_vld_r  <= prod_vld_nxt;
      prod_last_r <= prod_last_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/square_matrix_multiply_top.sv @@
// ----------------------------------------------------------------------------
// Square matrix multiplier, top level
// Load words fill the left and right stores, compute words emit product elements.
// ----------------------------------------------------------------------------
// Load words are taken one per cycle while idle and produce no result word. A
// compute word's result takes one store read per term through the shared MAC,
// then the read, multiply, accumulate and output registers. Input is held off
// until the result enters the output register, so no new word is taken before
// a compute word is through. Reset (rst_n, synchronous, active low) sets matrix_size
// to min(16, MAX_DIMENSION) and clears all positions; stores start undefined.
`default_nettype none

module square_matrix_multiply_top #(
  parameter int MAX_DIMENSION = smm_pkg::DEFAULT_MAX_DIMENSION,
  parameter int ELEMENT_WIDTH = smm_pkg::DEFAULT_ELEMENT_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration: matrix_size, written whenever cfg_wen is high.
  input  wire logic                                 cfg_wen,
  input  wire logic [smm_pkg::SIZE_WIDTH-1:0]       cfg_wdata,
  // Input stream.
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [smm_pkg::VALUE_WIDTH-1:0]      in_tdata,  // [15:0] element_value
  input  wire logic [smm_pkg::OPCODE_WIDTH-1:0]     in_tuser,  // [1:0] opcode
  // Result stream.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [35:0] product_value, [39:36] row_index, [43:40] column_index, [47:44] zero
  output logic [smm_pkg::OUT_DATA_WIDTH-1:0]        out_tdata,
  output logic                                      out_tlast   // last_element
);

  import smm_pkg::*;

  localparam int Depth = MAX_DIMENSION * MAX_DIMENSION;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = $clog2(MAX_DIMENSION);
  localparam int ResetN = (SIZE_RESET > MAX_DIMENSION) ? MAX_DIMENSION : SIZE_RESET;
  localparam int PadW  = OUT_DATA_WIDTH - PRODUCT_WIDTH - 2 * INDEX_WIDTH;

  // Sequencer states: waiting for a word, issuing store reads, draining the MAC.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t               state_r, state_nxt;

  // Active size: n-1, n as an address step, and n*n-1 for the position wrap.
  logic [IdxW-1:0]      n_m1_r,     n_m1_nxt;
  logic [AddrW-1:0]     n_step_r,   n_step_nxt;
  logic [AddrW-1:0]     count_m1_r, count_m1_nxt;

  // Load positions of both stores.
  logic [AddrW-1:0]     lpos_r, lpos_nxt;
  logic [AddrW-1:0]     rpos_r, rpos_nxt;

  // Output position kept as row and column; left_base_r is row * n.
  logic [IdxW-1:0]      row_r, row_nxt;
  logic [IdxW-1:0]      col_r, col_nxt;
  logic [AddrW-1:0]     left_base_r, left_base_nxt;

  // Read sequencing for one dot product.
  logic [IdxW-1:0]      k_r, k_nxt;
  logic [AddrW-1:0]     left_addr_r,  left_addr_nxt;
  logic [AddrW-1:0]     right_addr_r, right_addr_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [PRODUCT_WIDTH-1:0] out_prod_r,  out_prod_nxt;
  logic [INDEX_WIDTH-1:0]   out_row_r,   out_row_nxt;
  logic [INDEX_WIDTH-1:0]   out_col_r,   out_col_nxt;
  logic                     out_last_r,  out_last_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic                     row_end;
  logic                     col_end;
  logic                     left_we;
  logic                     right_we;
  logic [VALUE_WIDTH+ELEMENT_WIDTH-1:0] value_wide;
  logic [ELEMENT_WIDTH-1:0] element;
  logic [ELEMENT_WIDTH-1:0] left_rdata;
  logic [ELEMENT_WIDTH-1:0] right_rdata;
  logic [PRODUCT_WIDTH-1:0] mac_acc;
  logic                     mac_done;
  mac_ctrl_t                mac_ctrl;
  int                       size_sel;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign row_end   = (row_r == n_m1_r);
  assign col_end   = (col_r == n_m1_r);

  // The signed word is widened and its low ELEMENT_WIDTH bits are stored;
  // reads treat them as signed, which gives the sign extension from the top
  // stored bit.
  assign value_wide = {{ELEMENT_WIDTH{in_tdata[VALUE_WIDTH-1]}}, in_tdata};
  assign element    = value_wide[ELEMENT_WIDTH-1:0];
  assign left_we    = in_fire & (in_tuser == OP_LOAD_LEFT);
  assign right_we   = in_fire & (in_tuser == OP_LOAD_RIGHT);

  always_comb begin
    mac_ctrl.clear = in_fire & (in_tuser == OP_COMPUTE);
    mac_ctrl.issue = (state_r == S_RUN);
    mac_ctrl.last  = (k_r == n_m1_r);
  end

  always_comb begin
    state_nxt      = state_r;
    n_m1_nxt       = n_m1_r;
    n_step_nxt     = n_step_r;
    count_m1_nxt   = count_m1_r;
    lpos_nxt       = lpos_r;
    rpos_nxt       = rpos_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    left_base_nxt  = left_base_r;
    k_nxt          = k_r;
    left_addr_nxt  = left_addr_r;
    right_addr_nxt = right_addr_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_prod_nxt   = out_prod_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_last_nxt   = out_last_r;

    // A size of zero acts as one, and sizes above the store dimension saturate.
    size_sel = int'(cfg_wdata);
    if (size_sel == 0) begin
      size_sel = 1;
    end
    if (size_sel > MAX_DIMENSION) begin
      size_sel = MAX_DIMENSION;
    end

    // Load positions wrap after n*n elements.
    if (left_we) begin
      lpos_nxt = (lpos_r == count_m1_r) ? '0 : lpos_r + AddrW'(1);
    end
    if (right_we) begin
      rpos_nxt = (rpos_r == count_m1_r) ? '0 : rpos_r + AddrW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (mac_ctrl.clear) begin
          state_nxt      = S_RUN;
          k_nxt          = '0;
          left_addr_nxt  = left_base_r;
          right_addr_nxt = AddrW'(col_r);
        end
      end
      S_RUN: begin
        // Left walks along the row, right steps down the column.
        k_nxt          = k_r + IdxW'(1);
        left_addr_nxt  = left_addr_r + AddrW'(1);
        right_addr_nxt = right_addr_r + n_step_r;
        if (mac_ctrl.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done && out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_prod_nxt  = mac_acc;
          out_row_nxt   = INDEX_WIDTH'(row_r);
          out_col_nxt   = INDEX_WIDTH'(col_r);
          out_last_nxt  = row_end & col_end;
          if (col_end) begin
            col_nxt = '0;
            if (row_end) begin
              row_nxt       = '0;
              left_base_nxt = '0;
            end else begin
              row_nxt       = row_r + IdxW'(1);
              left_base_nxt = left_base_r + n_step_r;
            end
          end else begin
            col_nxt = col_r + IdxW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A size write restarts all positions; the user must write it only while idle, the block does not enforce this.
    if (cfg_wen) begin
      n_m1_nxt      = IdxW'(size_sel - 1);
      n_step_nxt    = AddrW'(size_sel);
      count_m1_nxt  = AddrW'(size_sel * size_sel - 1);
      lpos_nxt      = '0;
      rpos_nxt      = '0;
      row_nxt       = '0;
      col_nxt       = '0;
      left_base_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_m1_r      <= IdxW'(ResetN - 1);
      n_step_r    <= AddrW'(ResetN);
      count_m1_r  <= AddrW'(ResetN * ResetN - 1);
      lpos_r      <= '0;
      rpos_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      left_base_r <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_m1_r      <= n_m1_nxt;
      n_step_r    <= n_step_nxt;
      count_m1_r  <= count_m1_nxt;
      lpos_r      <= lpos_nxt;
      rpos_r      <= rpos_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      left_base_r <= left_base_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_addr_r  <= left_addr_nxt;
    right_addr_r <= right_addr_nxt;
    out_prod_r   <= out_prod_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_last_r   <= out_last_nxt;
  end

  smm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (Depth)
  ) u_left_store (
    .clk   (clk),
    .we    (left_we),
    .waddr (lpos_r),
    .wdata (element),
    .raddr (left_addr_r),
    .rdata (left_rdata)
  );

  smm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (Depth)
  ) u_right_store (
    .clk   (clk),
    .we    (right_we),
    .waddr (rpos_r),
    .wdata (element),
    .raddr (right_addr_r),
    .rdata (right_rdata)
  );

  smm_mac #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (mac_ctrl),
    .left_data  (left_rdata),
    .right_data (right_rdata),
    .acc        (mac_acc),
    .done       (mac_done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, out_col_r, out_row_r, out_prod_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
